// File: rtl/core/kpvt_pkg.sv
// shared types, constants and the microcode for the kalman tracker
// no dependencies
package kpvt_pkg;

  localparam int VW = 48;
  localparam int FB = 24;
  localparam int DIV_STEPS = VW + FB;

  typedef logic signed [VW-1:0] val_t;
  typedef logic [VW-2:0] uval_t;

  typedef enum logic [2:0] {
    CFG_TIME_STEP  = 3'd0,
    CFG_Q_POS      = 3'd1,
    CFG_Q_VEL      = 3'd2,
    CFG_MEAS_VAR   = 3'd3,
    CFG_INIT_POS   = 3'd4,
    CFG_INIT_VEL   = 3'd5,
    CFG_INIT_VAR   = 3'd6,
    CFG_UNUSED     = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    OPER_FILTER = 1'b0,
    OPER_REINIT = 1'b1
  } oper_t;

  typedef enum logic [1:0] {
    K_MUL = 2'd0,
    K_ADD = 2'd1,
    K_SUB = 2'd2,
    K_DIV = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    SRC_X   = 4'd0,
    SRC_V   = 4'd1,
    SRC_PP  = 4'd2,
    SRC_PV  = 4'd3,
    SRC_VV  = 4'd4,
    SRC_T   = 4'd5,
    SRC_S   = 4'd6,
    SRC_K0  = 4'd7,
    SRC_K1  = 4'd8,
    SRC_Y   = 4'd9,
    SRC_TMP = 4'd10,
    SRC_Z   = 4'd11,
    SRC_DT  = 4'd12,
    SRC_QP  = 4'd13,
    SRC_QV  = 4'd14,
    SRC_R   = 4'd15
  } src_t;

  typedef struct packed {
    kind_t kind;
    src_t  a;
    src_t  b;
    src_t  dst;
    logic  clamp;
  } uop_t;

  localparam int PROG_LEN = 22;
  localparam int PC_W = $clog2(PROG_LEN);

  localparam uop_t PROG [PROG_LEN] = '{
    '{K_MUL, SRC_DT,  SRC_PV,  SRC_TMP, 1'b0},
    '{K_ADD, SRC_PP,  SRC_TMP, SRC_T,   1'b0},
    '{K_MUL, SRC_DT,  SRC_VV,  SRC_TMP, 1'b0},
    '{K_ADD, SRC_PV,  SRC_TMP, SRC_PV,  1'b0},
    '{K_MUL, SRC_DT,  SRC_PV,  SRC_TMP, 1'b0},
    '{K_ADD, SRC_T,   SRC_TMP, SRC_TMP, 1'b0},
    '{K_ADD, SRC_TMP, SRC_QP,  SRC_PP,  1'b1},
    '{K_ADD, SRC_VV,  SRC_QV,  SRC_VV,  1'b1},
    '{K_MUL, SRC_DT,  SRC_V,   SRC_TMP, 1'b0},
    '{K_ADD, SRC_X,   SRC_TMP, SRC_X,   1'b0},
    '{K_ADD, SRC_PP,  SRC_R,   SRC_S,   1'b0},
    '{K_DIV, SRC_PP,  SRC_S,   SRC_K0,  1'b0},
    '{K_DIV, SRC_PV,  SRC_S,   SRC_K1,  1'b0},
    '{K_SUB, SRC_Z,   SRC_X,   SRC_Y,   1'b0},
    '{K_MUL, SRC_K0,  SRC_Y,   SRC_TMP, 1'b0},
    '{K_ADD, SRC_X,   SRC_TMP, SRC_X,   1'b0},
    '{K_MUL, SRC_K1,  SRC_Y,   SRC_TMP, 1'b0},
    '{K_ADD, SRC_V,   SRC_TMP, SRC_V,   1'b0},
    '{K_MUL, SRC_K0,  SRC_PP,  SRC_TMP, 1'b0},
    '{K_SUB, SRC_PP,  SRC_TMP, SRC_PP,  1'b1},
    '{K_MUL, SRC_K1,  SRC_PV,  SRC_TMP, 1'b0},
    '{K_SUB, SRC_VV,  SRC_TMP, SRC_VV,  1'b1}
  };
  // last step of the update, kept apart so pv is read unchanged above
  localparam uop_t PROG_LAST_MUL = '{K_MUL, SRC_K0, SRC_PV, SRC_TMP, 1'b0};
  localparam uop_t PROG_LAST_SUB = '{K_SUB, SRC_PV, SRC_TMP, SRC_PV, 1'b0};
  localparam int FULL_LEN = PROG_LEN + 2;
  localparam int FPC_W = $clog2(FULL_LEN);

endpackage

// File: rtl/core/kpvt_in_if.sv
// input channel of the kalman tracker: one measurement or reinit command
// depends on kpvt_pkg
interface kpvt_in_if import kpvt_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  val_t measurement;

  modport source (output valid, output operation, output measurement, input ready);
  modport sink (input valid, input operation, input measurement, output ready);
endinterface

// File: rtl/core/kpvt_out_if.sv
// output channel of the kalman tracker: estimates and covariance
// depends on kpvt_pkg
interface kpvt_out_if import kpvt_pkg::*; ();
  logic  valid;
  logic  ready;
  val_t  position_estimate;
  val_t  velocity_estimate;
  uval_t position_variance;
  val_t  cross_covariance;
  uval_t velocity_variance;
  logic  saturated;

  modport source (output valid, output position_estimate, output velocity_estimate,
                  output position_variance, output cross_covariance,
                  output velocity_variance, output saturated, input ready);
  modport sink (input valid, input position_estimate, input velocity_estimate,
                input position_variance, input cross_covariance,
                input velocity_variance, input saturated, output ready);
endinterface

// File: rtl/core/kalman_position_velocity_tracker.sv
// filter step: 9 multiplies on the shared 48x24 multiplier, two restoring divides on the
// one-bit-per-cycle divider and 13 adds or subtracts, then the output register; reinit loads
// the estimate straight from the config; a zero innovation variance ends both divides early;
// the block takes no new item until the last one has reached the output register, and an
// unread result waits while the next item comes in
// reset: synchronous active high, config to defaults, estimate loaded from defaults
// depends on kpvt_pkg, kpvt_in_if, kpvt_out_if
module kalman_position_velocity_tracker import kpvt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [2:0]        cfg_index,
  input  logic [VW-1:0]     cfg_data,
  kpvt_in_if.sink           measurements,
  kpvt_out_if.source        estimates
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EXEC,
    ST_DONE
  } state_t;

  // configuration registers
  uval_t time_step, q_pos, q_vel, meas_var, init_var;
  val_t  init_pos, init_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= uval_t'(48'd16777216);
      q_pos     <= uval_t'(48'd1678);
      q_vel     <= uval_t'(48'd1678);
      meas_var  <= uval_t'(48'd4194304);
      init_pos  <= val_t'(48'd8388608);
      init_vel  <= '0;
      init_var  <= uval_t'(48'd16777216);
    end else if (cfg_write_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIME_STEP: time_step <= cfg_data[VW-2:0];
        CFG_Q_POS:     q_pos     <= cfg_data[VW-2:0];
        CFG_Q_VEL:     q_vel     <= cfg_data[VW-2:0];
        CFG_MEAS_VAR:  meas_var  <= cfg_data[VW-2:0];
        CFG_INIT_POS:  init_pos  <= cfg_data;
        CFG_INIT_VEL:  init_vel  <= cfg_data;
        CFG_INIT_VAR:  init_var  <= cfg_data[VW-2:0];
        default: ;
      endcase
    end
  end

  // filter state and scratch registers
  val_t x, v, pp, pv, vv, t, s, k0, k1, y, tmp, z;

  state_t          state;
  logic [FPC_W-1:0] pc;
  logic [6:0]      cnt;
  val_t            opa, opb;
  logic [2*VW-1:0] acc;
  logic [DIV_STEPS-1:0] dq;
  logic [VW-1:0]   rem;
  logic            sat;
  logic            out_valid;

  // current micro-op
  uop_t uop;
  always_comb begin
    if (pc < FPC_W'(PROG_LEN)) uop = PROG[pc[PC_W-1:0]];
    else if (pc == FPC_W'(PROG_LEN)) uop = PROG_LAST_MUL;
    else uop = PROG_LAST_SUB;
  end

  // operand select
  function automatic val_t pick(input src_t sel, input val_t rx, input val_t rv,
                                input val_t rpp, input val_t rpv, input val_t rvv,
                                input val_t rt, input val_t rs, input val_t rk0,
                                input val_t rk1, input val_t ry, input val_t rtmp,
                                input val_t rz, input uval_t dt, input uval_t qp,
                                input uval_t qv, input uval_t r);
    val_t o;
    case (sel)
      SRC_X:   o = rx;
      SRC_V:   o = rv;
      SRC_PP:  o = rpp;
      SRC_PV:  o = rpv;
      SRC_VV:  o = rvv;
      SRC_T:   o = rt;
      SRC_S:   o = rs;
      SRC_K0:  o = rk0;
      SRC_K1:  o = rk1;
      SRC_Y:   o = ry;
      SRC_TMP: o = rtmp;
      SRC_Z:   o = rz;
      SRC_DT:  o = {1'b0, dt};
      SRC_QP:  o = {1'b0, qp};
      SRC_QV:  o = {1'b0, qv};
      SRC_R:   o = {1'b0, r};
      default: o = '0;
    endcase
    return o;
  endfunction

  val_t src_a, src_b;
  assign src_a = pick(uop.a, x, v, pp, pv, vv, t, s, k0, k1, y, tmp, z,
                      time_step, q_pos, q_vel, meas_var);
  assign src_b = pick(uop.b, x, v, pp, pv, vv, t, s, k0, k1, y, tmp, z,
                      time_step, q_pos, q_vel, meas_var);

  // magnitudes feeding the shared multiplier and divider
  logic [VW-1:0] mag_a, mag_b, mag_src_a;
  assign mag_a     = opa[VW-1] ? (~opa + 1'b1) : opa;
  assign mag_b     = opb[VW-1] ? (~opb + 1'b1) : opb;
  assign mag_src_a = src_a[VW-1] ? (~src_a + 1'b1) : src_a;

  // shared 48x24 multiplier, low half of b then high half
  logic [FB-1:0]      mb_part;
  logic [VW+FB-1:0]   partial;
  assign mb_part = cnt[0] ? mag_b[VW-1:FB] : mag_b[FB-1:0];
  assign partial = (VW+FB)'(mag_a) * (VW+FB)'(mb_part);

  // one restoring divide step
  logic [VW:0] rem_sh, dvs;
  logic        div_ge;
  assign rem_sh = {rem, dq[DIV_STEPS-1]};
  assign dvs    = {1'b0, opb};
  assign div_ge = rem_sh >= dvs;

  // result of the current micro-op, saturated
  localparam logic signed [2*VW:0] MUL_MAX = (2*VW+1)'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [2*VW:0] MUL_MIN = -(MUL_MAX + 1);

  logic signed [VW:0]   sum;
  logic signed [2*VW:0] prod_s, prod_sh;
  val_t                 res_raw, res;
  logic                 res_sat, clamp_hit;

  always_comb begin
    sum     = '0;
    prod_s  = '0;
    prod_sh = '0;
    res_raw = '0;
    res_sat = 1'b0;
    case (uop.kind)
      K_ADD, K_SUB: begin
        if (uop.kind == K_SUB) sum = {opa[VW-1], opa} - {opb[VW-1], opb};
        else sum = {opa[VW-1], opa} + {opb[VW-1], opb};
        if (sum[VW] != sum[VW-1]) begin
          res_sat = 1'b1;
          res_raw = sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
          res_raw = sum[VW-1:0];
        end
      end
      K_MUL: begin
        prod_s  = (opa[VW-1] ^ opb[VW-1]) ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
        prod_sh = prod_s >>> FB;
        if (prod_sh > MUL_MAX) begin
          res_sat = 1'b1;
          res_raw = {1'b0, {(VW-1){1'b1}}};
        end else if (prod_sh < MUL_MIN) begin
          res_sat = 1'b1;
          res_raw = {1'b1, {(VW-1){1'b0}}};
        end else begin
          res_raw = prod_sh[VW-1:0];
        end
      end
      K_DIV: begin
        // zero innovation variance gives zero gain
        if (opb == '0) begin
          res_raw = '0;
        end else if (opa[VW-1]) begin
          if (dq > DIV_STEPS'({1'b1, {(VW-1){1'b0}}})) begin
            res_sat = 1'b1;
            res_raw = {1'b1, {(VW-1){1'b0}}};
          end else begin
            res_raw = -$signed(dq[VW-1:0]);
          end
        end else if (dq > DIV_STEPS'({1'b0, {(VW-1){1'b1}}})) begin
          res_sat = 1'b1;
          res_raw = {1'b0, {(VW-1){1'b1}}};
        end else begin
          res_raw = dq[VW-1:0];
        end
      end
      default: ;
    endcase
    // variances never go below zero
    clamp_hit = uop.clamp && res_raw[VW-1];
    res = clamp_hit ? '0 : res_raw;
  end

  // micro-op finishes this cycle
  logic op_done;
  always_comb begin
    case (uop.kind)
      K_MUL:   op_done = cnt == 7'd2;
      K_DIV:   op_done = (opb == '0) || (cnt == 7'(DIV_STEPS));
      default: op_done = 1'b1;
    endcase
  end

  assign measurements.ready = state == ST_IDLE;
  assign estimates.valid    = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      cnt       <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
      x         <= val_t'(48'd8388608);
      v         <= '0;
      pp        <= val_t'(48'd16777216);
      pv        <= '0;
      vv        <= val_t'(48'd16777216);
    end else begin
      // output register loads from the done state, else clears on a transfer
      if (state == ST_DONE && (!out_valid || estimates.ready)) out_valid <= 1'b1;
      else if (out_valid && estimates.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (measurements.valid) begin
            sat <= 1'b0;
            pc  <= '0;
            if (oper_t'(measurements.operation) == OPER_REINIT) begin
              x     <= init_pos;
              v     <= init_vel;
              pp    <= {1'b0, init_var};
              pv    <= '0;
              vv    <= {1'b0, init_var};
              state <= ST_DONE;
            end else begin
              z     <= measurements.measurement;
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          opa   <= src_a;
          opb   <= src_b;
          cnt   <= '0;
          dq    <= {mag_src_a, {FB{1'b0}}};
          rem   <= '0;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (op_done) begin
            sat <= sat | res_sat | clamp_hit;
            case (uop.dst)
              SRC_X:   x   <= res;
              SRC_V:   v   <= res;
              SRC_PP:  pp  <= res;
              SRC_PV:  pv  <= res;
              SRC_VV:  vv  <= res;
              SRC_T:   t   <= res;
              SRC_S:   s   <= res;
              SRC_K0:  k0  <= res;
              SRC_K1:  k1  <= res;
              SRC_Y:   y   <= res;
              SRC_TMP: tmp <= res;
              default: ;
            endcase
            if (pc == FPC_W'(FULL_LEN - 1)) begin
              state <= ST_DONE;
            end else begin
              pc    <= pc + 1'b1;
              state <= ST_LOAD;
            end
          end else begin
            cnt <= cnt + 1'b1;
            case (uop.kind)
              K_MUL: begin
                if (cnt == 7'd0) acc <= {{FB{1'b0}}, partial};
                else acc <= acc + {partial, {FB{1'b0}}};
              end
              K_DIV: begin
                rem <= div_ge ? VW'(rem_sh - dvs) : rem_sh[VW-1:0];
                dq  <= {dq[DIV_STEPS-2:0], div_ge};
              end
              default: ;
            endcase
          end
        end
        ST_DONE: begin
          // output register is free or drains this cycle
          if (!out_valid || estimates.ready) begin
            estimates.position_estimate <= x;
            estimates.velocity_estimate <= v;
            estimates.position_variance <= pp[VW-2:0];
            estimates.cross_covariance  <= pv;
            estimates.velocity_variance <= vv[VW-2:0];
            estimates.saturated         <= sat;
            state                       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/kpvt_checker.sv
// port-level checks for the kalman tracker, bound to the top level
// depends on kalman_position_velocity_tracker ports
module kpvt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // the sequencer is busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while item in progress");

  // no result comes out of reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // a result appears only after an item was in the block
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a transfer in");

endmodule

bind kalman_position_velocity_tracker kpvt_checker u_kpvt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (measurements.valid),
  .in_ready  (measurements.ready),
  .out_valid (estimates.valid),
  .out_ready (estimates.ready)
);
